>>> hdl/vss_pkg.sv
`default_nettype none
package vss_pkg;

   localparam int DIM_W  = 14;   // padded dimensions, with room for height growth
   localparam int AREA_W = 27;   // padded_width * padded_height
   localparam int DVS_W  = 17;   // divisor width, holds 2047*64
   localparam int SIZE_W = 11;   // slice size candidates in both phases
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [DVS_W-1:0] COUNT_DIV = 17'd131008;   // 2047 * 64

   localparam logic [CSR_AW-1:0] CSR_MAX_NORMAL = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_MIN_NORMAL = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_MAX_ALT    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_MIN_ALT    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MAX_SLICES = 3'd4;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [12:0] frame_height;
      logic        profile_select;
   } req_type;

   typedef struct packed {
      logic [9:0]  slice_units;
      logic [12:0] padded_width;
      logic [12:0] padded_height;
      logic        search_status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_P1_MUL,
      S_P1_MULW,
      S_P1_TRY,
      S_P1_DIVW,
      S_P1_CNT,
      S_P1_CNTW,
      S_CHK_MUL,
      S_CHK_MULW,
      S_CHK_CNT,
      S_CHK_CNTW,
      S_P2_MUL,
      S_P2_MULW,
      S_P2_MW,
      S_P2_TRY,
      S_P2_DIVW,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

>>> hdl/vss_mul.sv
`default_nettype none
module vss_mul (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire [vss_pkg::DIM_W-1:0]  op_a,
   input  wire [vss_pkg::DIM_W-1:0]  op_b,
   output logic                      done,
   output logic [vss_pkg::AREA_W-1:0] product
);
   import vss_pkg::*;

   localparam int CNT_W = $clog2(DIM_W);

   logic [AREA_W-1:0] acc_ff, acc_in;
   logic [AREA_W-1:0] mcand_ff, mcand_in;
   logic [DIM_W-1:0]  mplier_ff, mplier_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // shift-add, one multiplier bit per cycle
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = AREA_W'(op_a);
         mplier_in = op_b;
         cnt_in    = CNT_W'(DIM_W - 1);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[AREA_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[DIM_W-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

>>> hdl/vss_div.sv
`default_nettype none
module vss_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire [vss_pkg::AREA_W-1:0]  dividend,
   input  wire [vss_pkg::DVS_W-1:0]   divisor,
   output logic                       done,
   output logic [vss_pkg::AREA_W-1:0] quotient,
   output logic [vss_pkg::DVS_W-1:0]  remainder
);
   import vss_pkg::*;

   localparam int CNT_W = $clog2(AREA_W);

   logic [AREA_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   // restoring division; dividend bits shift out of quo_ff as quotient bits shift in
   always_comb begin
      trial   = {rem_ff, quo_ff[AREA_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(AREA_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[AREA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[AREA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> hdl/video_slice_size_search_unit.sv
// Channel  | Ports                          | Moves
// request  | req_valid, req_ready, req_data | frame_width, frame_height, profile_select
// response | rsp_valid, rsp_ready, rsp_data | slice_units, padded dims, search_status
// csr      | csr_we, csr_addr, csr_wdata    | register writes, no wait
//
// One request at a time. Each multiply uses a 14-bit shift-add unit, each divide
// or modulo a 27-bit restoring divider; a request costs a few of these per round
// plus one divide per slice size tried, up to 2*RETRY_ROUNDS rounds. A finished
// response sits in an output register while the next request is taken. Reset is
// synchronous and restores the csr defaults.
`default_nettype none
module video_slice_size_search_unit #(
   parameter int MAX_DIMENSION = 4096,
   parameter int RETRY_ROUNDS  = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  vss_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output vss_pkg::rsp_type             rsp_data,
   input  wire                          csr_we,
   input  wire [vss_pkg::CSR_AW-1:0]    csr_addr,
   input  wire [vss_pkg::CSR_DW-1:0]    csr_wdata
);
   import vss_pkg::*;

   localparam int RND_W = (RETRY_ROUNDS > 1) ? $clog2(RETRY_ROUNDS) : 1;
   localparam logic [RND_W-1:0] LAST_RND = RND_W'(RETRY_ROUNDS - 1);

   logic [9:0]  max_n_ff, min_n_ff, max_a_ff, min_a_ff;
   logic [15:0] max_slices_ff;

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  pw_ff, pw_in, ph_ff, ph_in;
   logic [9:0]        lo_ff, lo_in;
   logic [SIZE_W-1:0] chosen_ff, chosen_in;
   logic [SIZE_W-1:0] s_ff, s_in;
   logic [SIZE_W:0]   lim_ff, lim_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mul_start, mul_done;
   logic [AREA_W-1:0] mul_prod;
   logic              div_start, div_done;
   logic [AREA_W-1:0] div_dvd, div_quo;
   logic [DVS_W-1:0]  div_dvs, div_rem;

   logic [12:0]       w_c, h_c;
   logic [DIM_W-1:0]  pw_new, ph_new;
   logic [9:0]        hi_sel, lo_sel;
   logic [SIZE_W-1:0] s_dn, s_up, m_raw, m_even;
   logic              cnt_over;

   vss_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (pw_ff),
      .op_b    (ph_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   vss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_n_ff      <= 10'd128;
         min_n_ff      <= 10'd2;
         max_a_ff      <= 10'd128;
         min_a_ff      <= 10'd2;
         max_slices_ff <= 16'd2047;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_NORMAL: max_n_ff      <= csr_wdata[9:0];
            CSR_MIN_NORMAL: min_n_ff      <= csr_wdata[9:0];
            CSR_MAX_ALT:    max_a_ff      <= csr_wdata[9:0];
            CSR_MIN_ALT:    min_a_ff      <= csr_wdata[9:0];
            CSR_MAX_SLICES: max_slices_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_c = ({2'b00, req_data.frame_width} > 15'(MAX_DIMENSION)) ?
            13'(MAX_DIMENSION) : req_data.frame_width;
      h_c = ({2'b00, req_data.frame_height} > 15'(MAX_DIMENSION)) ?
            13'(MAX_DIMENSION) : req_data.frame_height;
      pw_new = ({1'b0, w_c} + 14'd15) & 14'h3FF0;
      ph_new = ({1'b0, h_c} + 14'd7) & 14'h3FF8;
      hi_sel = req_data.profile_select ? max_a_ff : max_n_ff;
      lo_sel = req_data.profile_select ? min_a_ff : min_n_ff;
      s_dn   = s_ff - SIZE_W'(2);
      s_up   = s_ff + SIZE_W'(2);
      m_raw  = div_quo[SIZE_W-1:0];
      m_even = m_raw + SIZE_W'(m_raw[0]);
      cnt_over = div_quo > AREA_W'(max_slices_ff);
   end

   always_comb begin
      state_in     = state_ff;
      pw_in        = pw_ff;
      ph_in        = ph_ff;
      lo_in        = lo_ff;
      chosen_in    = chosen_ff;
      s_in         = s_ff;
      lim_in       = lim_ff;
      area_in      = area_ff;
      rnd_in       = rnd_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      div_dvd      = AREA_W'(area_ff >> 7);
      div_dvs      = DVS_W'(s_ff);

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pw_in     = pw_new;
               ph_in     = ph_new;
               lo_in     = lo_sel;
               chosen_in = SIZE_W'(hi_sel);
               rnd_in    = '0;
               found_in  = 1'b0;
               state_in  = S_P1_MUL;
            end
         end
         S_P1_MUL: begin
            mul_start = 1'b1;
            state_in  = S_P1_MULW;
         end
         S_P1_MULW: begin
            if (mul_done) begin
               area_in = mul_prod;
               // chosen still holds the profile maximum here
               s_in    = chosen_ff;
               state_in = (chosen_ff >= SIZE_W'(lo_ff)) ? S_P1_TRY : S_P1_CNT;
            end
         end
         S_P1_TRY: begin
            if (s_ff == '0) begin
               state_in = S_P1_CNT;
            end else begin
               div_start = 1'b1;
               state_in  = S_P1_DIVW;
            end
         end
         S_P1_DIVW: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  chosen_in = s_ff;
                  found_in  = 1'b1;
                  state_in  = S_CHK_MUL;
               end else if (s_ff < SIZE_W'(2) || s_dn < SIZE_W'(lo_ff)) begin
                  state_in = S_P1_CNT;
               end else begin
                  s_in     = s_dn;
                  state_in = S_P1_TRY;
               end
            end
         end
         S_P1_CNT: begin
            if (chosen_ff == '0) begin
               state_in = S_CHK_MUL;
            end else begin
               div_start = 1'b1;
               div_dvd   = AREA_W'(area_ff >> 6);
               div_dvs   = DVS_W'(chosen_ff);
               state_in  = S_P1_CNTW;
            end
         end
         S_P1_CNTW: begin
            if (div_done) begin
               if (cnt_over) begin
                  state_in = S_CHK_MUL;
               end else begin
                  ph_in = ph_ff + DIM_W'(8);
                  if (rnd_ff == LAST_RND) begin
                     state_in = S_CHK_MUL;
                  end else begin
                     rnd_in   = rnd_ff + 1'b1;
                     // restore the profile maximum as the first candidate
                     s_in     = chosen_ff;
                     state_in = S_P1_MUL;
                  end
               end
            end
         end
         S_CHK_MUL: begin
            mul_start = 1'b1;
            state_in  = S_CHK_MULW;
         end
         S_CHK_MULW: begin
            if (mul_done) begin
               area_in  = mul_prod;
               state_in = S_CHK_CNT;
            end
         end
         S_CHK_CNT: begin
            rnd_in = '0;
            if (chosen_ff == '0) begin
               state_in = S_P2_MUL;
            end else begin
               div_start = 1'b1;
               div_dvd   = AREA_W'(area_ff >> 6);
               div_dvs   = DVS_W'(chosen_ff);
               state_in  = S_CHK_CNTW;
            end
         end
         S_CHK_CNTW: begin
            if (div_done) begin
               state_in = cnt_over ? S_P2_MUL : S_DONE;
            end
         end
         S_P2_MUL: begin
            found_in  = 1'b0;
            mul_start = 1'b1;
            state_in  = S_P2_MULW;
         end
         S_P2_MULW: begin
            if (mul_done) begin
               area_in   = mul_prod;
               div_start = 1'b1;
               div_dvd   = mul_prod + AREA_W'(COUNT_DIV - 1'b1);
               div_dvs   = COUNT_DIV;
               state_in  = S_P2_MW;
            end
         end
         S_P2_MW: begin
            if (div_done) begin
               s_in   = m_even;
               lim_in = {m_even, 1'b0};
               if ({1'b0, m_even} < {m_even, 1'b0}) begin
                  state_in = S_P2_TRY;
               end else begin
                  ph_in = ph_ff + DIM_W'(8);
                  rnd_in = rnd_ff + 1'b1;
                  state_in = (rnd_ff == LAST_RND) ? S_DONE : S_P2_MUL;
               end
            end
         end
         S_P2_TRY: begin
            div_start = 1'b1;
            state_in  = S_P2_DIVW;
         end
         S_P2_DIVW: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  chosen_in = s_ff;
                  found_in  = 1'b1;
                  state_in  = S_DONE;
               end else if ({1'b0, s_up} < lim_ff) begin
                  s_in     = s_up;
                  state_in = S_P2_TRY;
               end else begin
                  ph_in  = ph_ff + DIM_W'(8);
                  rnd_in = rnd_ff + 1'b1;
                  state_in = (rnd_ff == LAST_RND) ? S_DONE : S_P2_MUL;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.slice_units   = chosen_ff[9:0];
               rsp_in.padded_width  = pw_ff[12:0];
               rsp_in.padded_height = ph_ff[12:0];
               rsp_in.search_status = !found_ff;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pw_ff     <= pw_in;
      ph_ff     <= ph_in;
      lo_ff     <= lo_in;
      chosen_ff <= chosen_in;
      s_ff      <= s_in;
      lim_ff    <= lim_in;
      area_ff   <= area_in;
      rnd_ff    <= rnd_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
